// File: rtl/rational_bezier_point_eval_assert.svh
// assertion macros for the rational bezier point evaluator
// used by the top level only, no other dependencies
`ifndef RATIONAL_BEZIER_POINT_EVAL_ASSERT_SVH
`define RATIONAL_BEZIER_POINT_EVAL_ASSERT_SVH

// same-cycle implication
`define RBPE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RBPE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/rbpe_pkg.sv
// shared types and constants of the rational bezier point evaluator
// no dependencies
package rbpe_pkg;

   localparam int MAX_POINTS_DEF = 16;

   localparam int COORD_W  = 32;
   localparam int WEIGHT_W = 16;
   localparam int SAMPLE_W = 10;
   localparam int ERR_W    = 2;
   localparam int FRAC_W   = 16;
   localparam int Q_W      = FRAC_W + 1;   // holds 1.0 in q1.16
   localparam int WB_W     = 24;           // weighted basis
   localparam int SUMW_W   = 30;           // weight sum over up to 64 points
   localparam int ACC_W    = 64;

   localparam logic [SAMPLE_W-1:0] SAMPLE_RESET = SAMPLE_W'(100);
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN   = SAMPLE_W'(50);
   localparam logic [Q_W-1:0]      ONE_Q        = Q_W'(65536);

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EVAL = 1'b1;

   localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
   localparam logic [ERR_W-1:0] ERR_EMPTY   = 2'd1;
   localparam logic [ERR_W-1:0] ERR_RANGE   = 2'd2;
   localparam logic [ERR_W-1:0] ERR_ZERO_WT = 2'd3;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [WEIGHT_W-1:0]       w;
   } point_type;

   typedef struct packed {
      logic              start;
      logic [ACC_W-1:0]  dividend;
      logic [SUMW_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [ACC_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: rtl/rbpe_if.sv
// request and response channel interfaces of the bezier evaluator
// depends on rbpe_pkg
interface rbpe_req_if;
   import rbpe_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       req_type;
   logic signed [COORD_W-1:0]  point_x;
   logic signed [COORD_W-1:0]  point_y;
   logic signed [COORD_W-1:0]  point_z;
   logic [WEIGHT_W-1:0]        point_weight;
   logic                       first_point;
   logic [SAMPLE_W-1:0]        sample_index;
   modport source (output valid, req_type, point_x, point_y, point_z, point_weight,
                   first_point, sample_index, input ready);
   modport sink (input valid, req_type, point_x, point_y, point_z, point_weight,
                 first_point, sample_index, output ready);
endinterface

interface rbpe_rsp_if;
   import rbpe_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [COORD_W-1:0]  curve_x;
   logic signed [COORD_W-1:0]  curve_y;
   logic signed [COORD_W-1:0]  curve_z;
   logic [ERR_W-1:0]           error_code;
   modport source (output valid, curve_x, curve_y, curve_z, error_code, input ready);
   modport sink (input valid, curve_x, curve_y, curve_z, error_code, output ready);
endinterface

// File: rtl/rational_bezier_point_eval.sv
// top level of the rational bezier point evaluator: sequencer, shared multiplier
// depends on rbpe_pkg, rbpe_if, rbpe_div, rbpe_store and the assertion header
//
// req_chan carries load transactions (req_type 0) that store a weighted control
// point, first_point restarting the set, and evaluate transactions (req_type 1)
// that ask for curve sample sample_index. Each evaluate gives one rsp_chan
// transaction with the saturated curve point and error_code; loads give none.
// csr_we writes sample_count (values below 50 act as 50); the user must write it
// only while the block is idle, which the block itself does not enforce.
// An evaluate holds req_chan.ready low through the bit-serial divider (run for t
// and for each coordinate), the in-place pascal row update (one ring rotation per
// row), one power step and seven shared-multiplier steps a point, and the load of
// the output register.
// Empty-store and range errors skip the arithmetic.
// The result sits in an output register; the next transaction is taken while it
// waits, but a new evaluate finishes only once the receiver has drained it.
// Synchronous reset empties the store, sets sample_count to 100 and drops
// rsp_chan.valid; store contents are not cleared.
module rational_bezier_point_eval #(
   parameter int MAX_POINTS = rbpe_pkg::MAX_POINTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   rbpe_req_if.sink                      req_chan,
   rbpe_rsp_if.source                    rsp_chan,
   input  logic                          csr_we,
   input  logic [rbpe_pkg::SAMPLE_W-1:0] csr_wdata
);
   import rbpe_pkg::*;

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int A_W   = WB_W + 1;
   localparam int B_W   = COORD_W + 1;
   localparam int P_W   = A_W + B_W;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_TSTART = 4'd1;
   localparam logic [3:0] ST_TWAIT  = 4'd2;
   localparam logic [3:0] ST_PASCAL = 4'd3;
   localparam logic [3:0] ST_UPOW   = 4'd4;
   localparam logic [3:0] ST_ACC    = 4'd5;
   localparam logic [3:0] ST_DSTART = 4'd6;
   localparam logic [3:0] ST_DWAIT  = 4'd7;
   localparam logic [3:0] ST_FINISH = 4'd8;

   logic [3:0]          state_ff;
   logic [SAMPLE_W-1:0] sample_count_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [IDX_W-1:0]    n_ff;
   logic [IDX_W-1:0]    k_ff;
   logic [IDX_W-1:0]    row_ff;
   logic [IDX_W-1:0]    col_ff;
   logic [2:0]          sub_ff;
   logic [1:0]          axis_ff;
   logic [SAMPLE_W-1:0] idx_ff;
   logic [SAMPLE_W-1:0] samples_ff;
   logic [ERR_W-1:0]    err_ff;
   logic [Q_W-1:0]      t_ff, u_ff, p_ff, tp_ff, q_ff, basis_ff, prev_ff;
   logic [WB_W-1:0]     wb_ff;
   logic [Q_W-1:0]      binom_ff [MAX_POINTS];
   logic [Q_W-1:0]      up_ff [MAX_POINTS];
   logic [SUMW_W-1:0]   sumw_ff;
   logic signed [ACC_W-1:0] acc_x_ff, acc_y_ff, acc_z_ff;
   logic signed [COORD_W-1:0] res_x_ff, res_y_ff, res_z_ff;
   logic                neg_ff;
   logic                rsp_valid_ff;

   logic                accept;
   logic [SAMPLE_W-1:0] samples_eff;
   logic [CNT_W-1:0]    load_base;
   logic                load_ok;
   point_type           wr_point;
   point_type           rd_point;
   div_req_type         div_req;
   div_rsp_type         div_rsp;
   logic signed [A_W-1:0] mul_a;
   logic signed [B_W-1:0] mul_b;
   logic signed [P_W-1:0] mul_p;
   logic signed [ACC_W-1:0] mul_ext;
   logic signed [ACC_W-1:0] acc_sel;
   logic [ACC_W-1:0]    acc_mag;
   logic [Q_W:0]        pas_sum;
   logic [Q_W-1:0]      pas_val;
   logic [COORD_W-1:0]  quo_sat;

   function automatic logic signed [A_W-1:0] ext_a(input logic [WB_W-1:0] v);
      return signed'({1'b0, v});
   endfunction

   assign accept      = req_chan.valid && req_chan.ready;
   assign samples_eff = (sample_count_ff < SAMPLE_MIN) ? SAMPLE_MIN : sample_count_ff;
   assign load_base   = req_chan.first_point ? '0 : count_ff;
   assign load_ok     = req_chan.first_point || (count_ff < CNT_W'(MAX_POINTS));

   assign wr_point.x = req_chan.point_x;
   assign wr_point.y = req_chan.point_y;
   assign wr_point.z = req_chan.point_z;
   assign wr_point.w = req_chan.point_weight;

   rbpe_store #(.DEPTH(MAX_POINTS)) u_store (
      .clock   (clock),
      .wr_en   (accept && (req_chan.req_type == REQ_LOAD) && load_ok),
      .wr_addr (load_base[IDX_W-1:0]),
      .wr_data (wr_point),
      .rd_addr (k_ff),
      .rd_data (rd_point)
   );

   // shared multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_UPOW: begin
            mul_a = ext_a(WB_W'(p_ff));
            mul_b = B_W'(u_ff);
         end
         ST_ACC: begin
            case (sub_ff)
               3'd0: begin
                  mul_a = ext_a(WB_W'(up_ff[0]));
                  mul_b = B_W'(tp_ff);
               end
               3'd1: begin
                  mul_a = ext_a(WB_W'(binom_ff[0]));
                  mul_b = B_W'(q_ff);
               end
               3'd2: begin
                  mul_a = ext_a(WB_W'(basis_ff));
                  mul_b = B_W'(rd_point.w);
               end
               3'd3: begin
                  mul_a = ext_a(wb_ff);
                  mul_b = B_W'(rd_point.x);
               end
               3'd4: begin
                  mul_a = ext_a(wb_ff);
                  mul_b = B_W'(rd_point.y);
               end
               3'd5: begin
                  mul_a = ext_a(wb_ff);
                  mul_b = B_W'(rd_point.z);
               end
               default: begin
                  mul_a = ext_a(WB_W'(tp_ff));
                  mul_b = B_W'(t_ff);
               end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p   = mul_a * mul_b;
      mul_ext = {{(ACC_W-P_W){mul_p[P_W-1]}}, mul_p};
   end

   // saturating pascal add; a saturated entry only ever meets a zero power term
   assign pas_sum = {1'b0, binom_ff[0]} + {1'b0, prev_ff};
   assign pas_val = pas_sum[Q_W] ? '1 : pas_sum[Q_W-1:0];

   always_comb begin
      case (axis_ff)
         2'd0:    acc_sel = acc_x_ff;
         2'd1:    acc_sel = acc_y_ff;
         default: acc_sel = acc_z_ff;
      endcase
      acc_mag = acc_sel[ACC_W-1] ? ACC_W'(-acc_sel) : ACC_W'(acc_sel);
   end

   always_comb begin
      div_req.start    = (state_ff == ST_TSTART) || (state_ff == ST_DSTART);
      div_req.dividend = (state_ff == ST_TSTART) ?
                         ACC_W'({idx_ff, {FRAC_W{1'b0}}}) : acc_mag;
      div_req.divisor  = (state_ff == ST_TSTART) ? SUMW_W'(samples_ff) : sumw_ff;
   end

   rbpe_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // truncated quotient, saturated to the signed 32-bit range
   always_comb begin
      logic [ACC_W-1:0] nq;
      nq = -div_rsp.quotient;
      if (!neg_ff) begin
         quo_sat = (|div_rsp.quotient[ACC_W-1:COORD_W-1]) ?
                   {1'b0, {(COORD_W-1){1'b1}}} : div_rsp.quotient[COORD_W-1:0];
      end else if ((|div_rsp.quotient[ACC_W-1:COORD_W]) ||
                   (div_rsp.quotient[COORD_W-1] && (|div_rsp.quotient[COORD_W-2:0]))) begin
         quo_sat = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         quo_sat = nq[COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         sample_count_ff <= SAMPLE_RESET;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            sample_count_ff <= csr_wdata;
         end
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_chan.req_type == REQ_LOAD) begin
                     if (load_ok) begin
                        count_ff <= load_base + CNT_W'(1);
                     end
                  end else begin
                     res_x_ff   <= '0;
                     res_y_ff   <= '0;
                     res_z_ff   <= '0;
                     acc_x_ff   <= '0;
                     acc_y_ff   <= '0;
                     acc_z_ff   <= '0;
                     sumw_ff    <= '0;
                     idx_ff     <= req_chan.sample_index;
                     samples_ff <= samples_eff;
                     n_ff       <= IDX_W'(count_ff - CNT_W'(1));
                     if (count_ff == '0) begin
                        err_ff   <= ERR_EMPTY;
                        state_ff <= ST_FINISH;
                     end else if (req_chan.sample_index >= samples_eff) begin
                        err_ff   <= ERR_RANGE;
                        state_ff <= ST_FINISH;
                     end else begin
                        err_ff   <= ERR_OK;
                        state_ff <= ST_TSTART;
                     end
                  end
               end
            end
            ST_TSTART: begin
               state_ff <= ST_TWAIT;
            end
            ST_TWAIT: begin
               if (div_rsp.done) begin
                  t_ff    <= div_rsp.quotient[Q_W-1:0];
                  u_ff    <= ONE_Q - div_rsp.quotient[Q_W-1:0];
                  p_ff    <= ONE_Q;
                  prev_ff <= '0;
                  row_ff  <= IDX_W'(1);
                  col_ff  <= '0;
                  k_ff    <= '0;
                  for (int i = 0; i < MAX_POINTS; i++) begin
                     binom_ff[i] <= (i == 0) ? Q_W'(1) : '0;
                  end
                  state_ff <= (n_ff == '0) ? ST_UPOW : ST_PASCAL;
               end
            end
            ST_PASCAL: begin
               // rotate the ring once per row, adding each entry to its left neighbour
               for (int i = 0; i < MAX_POINTS - 1; i++) begin
                  binom_ff[i] <= binom_ff[i+1];
               end
               binom_ff[MAX_POINTS-1] <= pas_val;
               if (col_ff == IDX_W'(MAX_POINTS - 1)) begin
                  col_ff  <= '0;
                  prev_ff <= '0;
                  if (row_ff == n_ff) begin
                     state_ff <= ST_UPOW;
                  end else begin
                     row_ff <= row_ff + IDX_W'(1);
                  end
               end else begin
                  col_ff  <= col_ff + IDX_W'(1);
                  prev_ff <= binom_ff[0];
               end
            end
            ST_UPOW: begin
               // after the last push the head holds (1-t)^n
               up_ff[0] <= p_ff;
               for (int i = 1; i < MAX_POINTS; i++) begin
                  up_ff[i] <= up_ff[i-1];
               end
               p_ff <= mul_p[2*FRAC_W:FRAC_W];
               if (k_ff == n_ff) begin
                  k_ff     <= '0;
                  sub_ff   <= '0;
                  tp_ff    <= ONE_Q;
                  state_ff <= ST_ACC;
               end else begin
                  k_ff <= k_ff + IDX_W'(1);
               end
            end
            ST_ACC: begin
               sub_ff <= sub_ff + 3'd1;
               case (sub_ff)
                  3'd0: q_ff     <= mul_p[2*FRAC_W:FRAC_W];
                  3'd1: basis_ff <= mul_p[Q_W-1:0];
                  3'd2: wb_ff    <= mul_p[WB_W+7:8];
                  3'd3: begin
                     acc_x_ff <= acc_x_ff + mul_ext;
                     sumw_ff  <= sumw_ff + SUMW_W'(wb_ff);
                  end
                  3'd4: acc_y_ff <= acc_y_ff + mul_ext;
                  3'd5: acc_z_ff <= acc_z_ff + mul_ext;
                  default: begin
                     sub_ff <= '0;
                     tp_ff  <= mul_p[2*FRAC_W:FRAC_W];
                     for (int i = 0; i < MAX_POINTS - 1; i++) begin
                        up_ff[i]    <= up_ff[i+1];
                        binom_ff[i] <= binom_ff[i+1];
                     end
                     up_ff[MAX_POINTS-1]    <= '0;
                     binom_ff[MAX_POINTS-1] <= binom_ff[0];
                     axis_ff <= 2'd0;
                     if (k_ff == n_ff) begin
                        if (sumw_ff == '0) begin
                           err_ff   <= ERR_ZERO_WT;
                           state_ff <= ST_FINISH;
                        end else begin
                           state_ff <= ST_DSTART;
                        end
                     end else begin
                        k_ff <= k_ff + IDX_W'(1);
                     end
                  end
               endcase
            end
            ST_DSTART: begin
               neg_ff   <= acc_sel[ACC_W-1];
               state_ff <= ST_DWAIT;
            end
            ST_DWAIT: begin
               if (div_rsp.done) begin
                  case (axis_ff)
                     2'd0:    res_x_ff <= signed'(quo_sat);
                     2'd1:    res_y_ff <= signed'(quo_sat);
                     default: res_z_ff <= signed'(quo_sat);
                  endcase
                  if (axis_ff == 2'd2) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     axis_ff  <= axis_ff + 2'd1;
                     state_ff <= ST_DSTART;
                  end
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_chan.curve_x    <= res_x_ff;
                  rsp_chan.curve_y    <= res_y_ff;
                  rsp_chan.curve_z    <= res_z_ff;
                  rsp_chan.error_code <= err_ff;
                  state_ff            <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;

`include "rational_bezier_point_eval_assert.svh"

   `RBPE_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_POINTS), "point count past store depth")
   `RBPE_ASSERT_NEXT(a_eval_busy, clock, reset, accept && (req_chan.req_type == REQ_EVAL), state_ff != ST_IDLE, "evaluate transaction did not start work")
   `RBPE_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid_ff && (rsp_chan.error_code != ERR_OK), (rsp_chan.curve_x == '0) && (rsp_chan.curve_y == '0) && (rsp_chan.curve_z == '0), "error result with nonzero point")
   `RBPE_ASSERT_NOW(a_div_idle, clock, reset, div_req.start, !div_rsp.busy, "divider restarted while busy")

endmodule

// File: rtl/rbpe_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on rbpe_pkg
module rbpe_div (
   input  logic                  clock,
   input  logic                  reset,
   input  rbpe_pkg::div_req_type req,
   output rbpe_pkg::div_rsp_type rsp
);
   import rbpe_pkg::*;

   localparam int CNT_W = $clog2(ACC_W + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [SUMW_W-1:0] rem_ff;
   logic [SUMW_W-1:0] dsr_ff;
   logic [ACC_W-1:0]  quo_ff;

   logic [SUMW_W:0]   trial;
   logic              ge;
   logic [SUMW_W:0]   diff;

   always_comb begin
      trial = {rem_ff, quo_ff[ACC_W-1]};
      ge    = trial >= {1'b0, dsr_ff};
      diff  = trial - {1'b0, dsr_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(ACC_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // dividend shifts out at the top while quotient bits enter at the bottom
   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= '0;
         dsr_ff <= req.divisor;
         quo_ff <= req.dividend;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[SUMW_W-1:0] : trial[SUMW_W-1:0];
         quo_ff <= {quo_ff[ACC_W-2:0], ge};
      end
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// File: rtl/rbpe_store.sv
// control point store, one write and one registered read port
// depends on rbpe_pkg
module rbpe_store #(
   parameter int DEPTH = rbpe_pkg::MAX_POINTS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  rbpe_pkg::point_type      wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output rbpe_pkg::point_type      rd_data
);
   import rbpe_pkg::*;

   point_type mem [DEPTH];
   point_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

// File: sim/rbpe_checker.sv
// checker for the rational bezier point evaluator: watches both channels and the csr port
// keeps its own control store and predicts each curve sample; depends on rbpe_pkg, rbpe_if
`timescale 1ns / 1ps

module rbpe_checker (
   input  logic                          clock,
   input  logic                          reset,
   rbpe_req_if                           req_mon,
   rbpe_rsp_if                           rsp_mon,
   input  logic                          csr_we,
   input  logic [rbpe_pkg::SAMPLE_W-1:0] csr_wdata,
   output int                            fail_count,
   output int                            samples_owed
);
   import rbpe_pkg::*;

   localparam int STORE_DEPTH = MAX_POINTS_DEF;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [ERR_W-1:0]          err;
   } curve_pt_type;

   point_type        ctl_store [STORE_DEPTH];
   int unsigned      ctl_count;
   logic [SAMPLE_W-1:0] sample_count;
   curve_pt_type     curve_due [$];

   function automatic logic signed [COORD_W-1:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[COORD_W-1:0];
   endfunction

   function automatic curve_pt_type curve_at(logic [SAMPLE_W-1:0] idx);
      longint unsigned binom [STORE_DEPTH];
      longint unsigned tp [STORE_DEPTH];
      longint unsigned up [STORE_DEPTH];
      longint unsigned t, u, sum_w, basis, wb;
      longint          sx, sy, sz;
      int unsigned     samples, n;
      curve_pt_type    res;
      res.x = '0; res.y = '0; res.z = '0; res.err = ERR_OK;
      samples = (sample_count < SAMPLE_MIN) ? SAMPLE_MIN : sample_count;
      if (ctl_count == 0) begin
         res.err = ERR_EMPTY;
         return res;
      end
      if (idx >= samples) begin
         res.err = ERR_RANGE;
         return res;
      end
      n = ctl_count - 1;
      t = (longint'(idx) * 65536) / samples;
      u = 65536 - t;
      binom[0] = 1;
      for (int r = 1; r <= n; r++) begin
         binom[r] = 1;
         for (int k = r - 1; k > 0; k--) binom[k] += binom[k-1];
      end
      tp[0] = 65536;
      up[0] = 65536;
      for (int k = 1; k <= n; k++) begin
         tp[k] = (tp[k-1] * t) >> 16;
         up[k] = (up[k-1] * u) >> 16;
      end
      sum_w = 0; sx = 0; sy = 0; sz = 0;
      for (int k = 0; k <= n; k++) begin
         basis = binom[k] * ((up[n-k] * tp[k]) >> 16);
         wb    = (basis * ctl_store[k].w) >> 8;
         sum_w += wb;
         sx += longint'(wb) * longint'(ctl_store[k].x);
         sy += longint'(wb) * longint'(ctl_store[k].y);
         sz += longint'(wb) * longint'(ctl_store[k].z);
      end
      if (sum_w == 0) begin
         res.err = ERR_ZERO_WT;
      end else begin
         res.x = clamp32(sx / longint'(sum_w));
         res.y = clamp32(sy / longint'(sum_w));
         res.z = clamp32(sz / longint'(sum_w));
      end
      return res;
   endfunction

   assign samples_owed = curve_due.size();

   always @(posedge clock) begin
      curve_pt_type exp_pt;
      if (reset) begin
         ctl_count    <= 0;
         sample_count <= SAMPLE_RESET;
         fail_count   <= 0;
         curve_due.delete();
      end else begin
         if (csr_we) sample_count <= csr_wdata;
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.req_type == REQ_LOAD) begin
               // a full store ignores further loads unless one restarts the set
               if (req_mon.first_point) begin
                  ctl_store[0] <= '{req_mon.point_x, req_mon.point_y, req_mon.point_z,
                                    req_mon.point_weight};
                  ctl_count <= 1;
               end else if (ctl_count < STORE_DEPTH) begin
                  ctl_store[ctl_count] <= '{req_mon.point_x, req_mon.point_y,
                                            req_mon.point_z, req_mon.point_weight};
                  ctl_count <= ctl_count + 1;
               end
            end else begin
               curve_due.push_back(curve_at(req_mon.sample_index));
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (curve_due.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("unexpected curve transaction x=%h y=%h z=%h err=%0d",
                           rsp_mon.curve_x, rsp_mon.curve_y, rsp_mon.curve_z,
                           rsp_mon.error_code);
            end else begin
               exp_pt = curve_due.pop_front();
               if (rsp_mon.curve_x !== exp_pt.x || rsp_mon.curve_y !== exp_pt.y ||
                   rsp_mon.curve_z !== exp_pt.z || rsp_mon.error_code !== exp_pt.err) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display({"curve mismatch: exp x=%h y=%h z=%h err=%0d ",
                               "got x=%h y=%h z=%h err=%0d"},
                              exp_pt.x, exp_pt.y, exp_pt.z, exp_pt.err, rsp_mon.curve_x,
                              rsp_mon.curve_y, rsp_mon.curve_z, rsp_mon.error_code);
               end
            end
         end
      end
   end

endmodule

// File: sim/tb_top.sv
// top of the bezier evaluator testbench: clock, reset, stimulus and verdict
// depends on rbpe_pkg, rbpe_if, rbpe_checker and the block itself
`timescale 1ns / 1ps

module tb_top;
   import rbpe_pkg::*;

   localparam longint CYCLE_LIMIT = 4000000;
   localparam int      PHASE_ITEMS = 425;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_we;
   logic [SAMPLE_W-1:0] csr_wdata;
   int                  fail_count, samples_owed;
   int                  send_idle_pct, recv_stall_pct;
   longint              cycles = 0;

   rbpe_req_if req_chan ();
   rbpe_rsp_if rsp_chan ();

   rational_bezier_point_eval u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   rbpe_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_chan),
      .rsp_mon      (rsp_chan),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .samples_owed (samples_owed)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

   // one transaction, with a random idle gap ahead of it
   task automatic drive_req(logic kind, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            logic [15:0] pw, logic first, logic [9:0] idx);
      logic took;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.req_type     <= kind;
      req_chan.point_x      <= px;
      req_chan.point_y      <= py;
      req_chan.point_z      <= pz;
      req_chan.point_weight <= pw;
      req_chan.first_point  <= first;
      req_chan.sample_index <= idx;
      do begin
         @(negedge clock);
         took = req_chan.ready;
         @(posedge clock);
      end while (!took);
   endtask

   task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [15:0] pw, logic first);
      drive_req(REQ_LOAD, px, py, pz, pw, first, 10'($urandom));
   endtask

   task automatic ask_sample(logic [9:0] idx);
      drive_req(REQ_EVAL, $urandom, $urandom, $urandom, 16'($urandom), 1'($urandom), idx);
   endtask

   task automatic write_sample_count(logic [SAMPLE_W-1:0] v);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (samples_owed != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] rand_weight();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'h0100;
         2: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int unsigned samples, npts, sent;
      logic [SAMPLE_W-1:0] phase_count [4];
      req_chan.valid        <= 1'b0;
      req_chan.req_type     <= REQ_LOAD;
      req_chan.point_x      <= '0;
      req_chan.point_y      <= '0;
      req_chan.point_z      <= '0;
      req_chan.point_weight <= '0;
      req_chan.first_point  <= 1'b0;
      req_chan.sample_index <= '0;
      csr_we         <= 1'b0;
      csr_wdata      <= '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty store, extremes, range edges, zero weight sum, full store
      ask_sample(10'd0);
      send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'hffff, 1'b1);
      send_point(32'h80000000, 32'h7fffffff, 32'h80000000, 16'h0001, 1'b0);
      ask_sample(10'd0);
      ask_sample(10'd99);
      ask_sample(10'd100);
      ask_sample(10'd1022);
      write_sample_count(10'd0);        // below the floor, acts as fifty
      ask_sample(10'd49);
      ask_sample(10'd50);
      write_sample_count(10'd1023);
      ask_sample(10'd1022);
      ask_sample(10'd511);
      send_point(32'h00010000, 32'h00020000, 32'hfffd0000, 16'h0000, 1'b1);
      ask_sample(10'd5);
      send_point(32'h00050000, 32'h0, 32'h0, 16'h0000, 1'b0);
      ask_sample(10'd0);
      for (int i = 0; i < 17; i++)      // the last one overflows the store
         send_point(rand_coord(), rand_coord(), rand_coord(), rand_weight(), i == 0);
      ask_sample(10'd300);
      ask_sample(10'd1000);

      phase_count[0] = 10'd50;
      phase_count[1] = 10'd1023;
      phase_count[2] = 10'($urandom_range(50, 1023));
      phase_count[3] = 10'($urandom_range(0, 49));
      for (int ph = 0; ph < 4; ph++) begin
         write_sample_count(phase_count[ph]);
         samples = (phase_count[ph] < 50) ? 50 : phase_count[ph];
         send_idle_pct  = (ph == 1) ? 74 : (ph == 3) ? 15 : 0;
         recv_stall_pct = (ph == 2) ? 74 : (ph == 3) ? 15 : 0;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
               // noise: stray load or evaluate anywhere in the index range
               if ($urandom_range(0, 1))
                  send_point(rand_coord(), rand_coord(), rand_coord(), rand_weight(), 1'b0);
               else
                  ask_sample(10'($urandom_range(0, 1022)));
               sent++;
            end else begin
               npts = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16)
                                                  : $urandom_range(1, 5);
               for (int i = 0; i < npts; i++)
                  send_point(rand_coord(), rand_coord(), rand_coord(), rand_weight(), i == 0);
               sent += npts;
               for (int e = $urandom_range(1, 4); e > 0; e--) begin
                  case ($urandom_range(0, 5))
                     0: ask_sample(10'd0);
                     1: ask_sample(10'(samples - 1));
                     default: ask_sample(10'($urandom_range(0, samples - 1)));
                  endcase
                  sent++;
               end
            end
         end
      end

      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (samples_owed != 0) @(posedge clock);
      repeat (800) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
